// ===== rtl/fcr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the framed command responder.
package fcr_pkg;

    localparam int MAX_FRAME_BYTES = 52;
    localparam int MAX_BODY_BYTES  = MAX_FRAME_BYTES - 2;
    localparam int DESC_DEPTH      = 4;
    localparam int DESC_PTR_W      = $clog2(DESC_DEPTH);

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_XOR     = 8'h20;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CRC_XOROUT  = 8'h55;
    localparam logic [7:0] CMD_VERSION = 8'hA0;

    localparam logic [7:0] LEN_VERSION = 8'd8;
    localparam logic [7:0] LEN_SHORT   = 8'd6;

    localparam logic [7:0] REG_OWN_ADDR           = 8'd0;
    localparam logic [7:0] REG_VER_HI             = 8'd1;
    localparam logic [7:0] REG_VER_LO             = 8'd2;
    localparam logic [7:0] REG_STATUS_SUCCESS     = 8'd3;
    localparam logic [7:0] REG_STATUS_CRC_ERROR   = 8'd4;
    localparam logic [7:0] REG_STATUS_UNSUPPORTED = 8'd5;

    typedef enum logic [1:0] {
        RESP_VERSION,
        RESP_UNSUPPORTED,
        RESP_CRC_ERROR
    } t_resp_kind;

    typedef struct packed {
        t_resp_kind  kind;
        logic [7:0]  cmd;
    } t_resp_desc;

    typedef struct packed {
        logic [7:0] own_addr;
        logic [7:0] ver_hi;
        logic [7:0] ver_lo;
        logic [7:0] status_success;
        logic [7:0] status_crc_error;
        logic [7:0] status_unsupported;
    } t_cfg;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// ===== rtl/framed_command_responder_unit.sv =====
// Top level of the framed command responder: configuration registers and the byte path.
//
// Raw link bytes enter through push/full at one byte per clock while full is low. A 0x7E flag bounds a frame,
// 0x7D escapes the following byte (XOR 0x20), and the destuffed body is address, length high,
// length low, command, parameters and a CRC-8 (poly 0x07, init 0, xorout 0x55) checked on the
// fly with no frame buffer. Frames that are too long, whose body count differs from the length
// low byte, that are shorter than five bytes or that carry a foreign address are dropped without
// a trace. Every other frame yields one response on the result side, one wire byte per transfer:
// opening flag, address, 0, length, command, status, major and minor version for command 0xA0,
// CRC, closing flag, all stuffed; last_of_response marks the closing flag. A response is 8 to
// 15 wire bytes (8 for a status reply with nothing to stuff, 15 for a version reply with five
// escaped bytes), built one byte per clock into an output register while pops keep up, the
// builder idling between responses while the next request is loaded. Up to four accepted
// responses wait in a request queue between the deframer and the builder; full rises only
// when that queue is full. A response holds the result side longer than the shortest frame of six
// link bytes, so input stalls under a long run of short frames as well as when the result side
// is held off. Configuration registers are written through i_cfg_wr_en/i_cfg_index/i_cfg_data
// and take effect at the next clock; write them only while no response is pending. Indexes
// beyond the register list are ignored.
module framed_command_responder_unit
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_response,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg        r_cfg;
    logic        rx_transfer;
    logic        desc_push;
    t_resp_desc  desc_in;
    t_resp_desc  desc_out;
    logic        desc_empty;
    logic        desc_pop;

    // Configuration registers; hold unless written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_addr           <= 8'h30;
            r_cfg.ver_hi             <= 8'h00;
            r_cfg.ver_lo             <= 8'h00;
            r_cfg.status_success     <= 8'h00;
            r_cfg.status_crc_error   <= 8'h01;
            r_cfg.status_unsupported <= 8'h02;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_OWN_ADDR:           r_cfg.own_addr           <= i_cfg_data;
                REG_VER_HI:             r_cfg.ver_hi             <= i_cfg_data;
                REG_VER_LO:             r_cfg.ver_lo             <= i_cfg_data;
                REG_STATUS_SUCCESS:     r_cfg.status_success     <= i_cfg_data;
                REG_STATUS_CRC_ERROR:   r_cfg.status_crc_error   <= i_cfg_data;
                REG_STATUS_UNSUPPORTED: r_cfg.status_unsupported <= i_cfg_data;
                default:                r_cfg                    <= r_cfg;
            endcase
        end
    end

    // Accept a byte whenever the request queue has room for a possible response.
    assign rx_transfer = push && !full;

    fcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (rx_transfer),
        .i_rx_byte   (i_rx_byte),
        .i_own_addr  (r_cfg.own_addr),
        .o_desc_push (desc_push),
        .o_desc      (desc_in)
    );

    fcr_desc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_desc  (desc_out),
        .o_empty (desc_empty),
        .o_full  (full)
    );

    fcr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_desc             (desc_out),
        .i_desc_empty       (desc_empty),
        .o_desc_pop         (desc_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_tx_byte          (o_tx_byte),
        .o_last_of_response (o_last_of_response)
    );

endmodule

// ===== rtl/fcr_front.sv =====
// Receive deframer: destuffs bytes, runs the CRC and checks, queues response requests.
module fcr_front
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_own_addr,
    output logic        o_desc_push,
    output t_resp_desc  o_desc
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [5:0]  r_count,      n_count;
    logic        r_too_long,   n_too_long;
    logic [7:0]  r_addr,       n_addr;
    logic [7:0]  r_length,     n_length;
    logic [7:0]  r_cmd,        n_cmd;
    logic [7:0]  r_crc,        n_crc;
    logic [7:0]  r_prev,       n_prev;

    logic        body_take;
    logic [7:0]  body_byte;
    logic        open_frame;
    logic        close_ok;
    logic        crc_ok;

    assign crc_ok   = (r_crc ^ CRC_XOROUT) == r_prev;
    assign close_ok = !r_too_long && (r_count >= 6'd5)
                    && (r_length == {2'b00, r_count})
                    && (r_addr == i_own_addr);

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_too_long = r_too_long;
        n_addr     = r_addr;
        n_length   = r_length;
        n_cmd      = r_cmd;
        n_crc      = r_crc;
        n_prev     = r_prev;
        body_take  = 1'b0;
        body_byte  = i_rx_byte;
        open_frame = 1'b0;
        o_desc_push = 1'b0;

        if (i_valid) begin
            case (r_phase)
                PH_BODY: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        o_desc_push = close_ok;
                        open_frame  = 1'b1;
                    end else if (i_rx_byte == ESC_BYTE) begin
                        n_phase = PH_ESC;
                    end else begin
                        body_take = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        open_frame = 1'b1;
                    end else begin
                        n_phase   = PH_BODY;
                        body_take = 1'b1;
                        body_byte = i_rx_byte ^ ESC_XOR;
                    end
                end
                default: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        open_frame = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            endcase
        end

        if (body_take && !r_too_long) begin
            if (r_count >= 6'(MAX_BODY_BYTES)) begin
                n_too_long = 1'b1;
            end else begin
                if (r_count == 6'd0) n_addr   = body_byte;
                if (r_count == 6'd2) n_length = body_byte;
                if (r_count == 6'd3) n_cmd    = body_byte;
                if (r_count != 6'd0) n_crc    = crc8_step(r_crc, r_prev);
                n_prev  = body_byte;
                n_count = r_count + 6'd1;
            end
        end

        if (open_frame) begin
            n_phase    = PH_BODY;
            n_count    = '0;
            n_too_long = 1'b0;
            n_addr     = '0;
            n_length   = '0;
            n_cmd      = '0;
            n_crc      = '0;
            n_prev     = '0;
        end
    end

    always_comb begin
        o_desc.cmd = r_cmd;
        if (!crc_ok) begin
            o_desc.kind = RESP_CRC_ERROR;
        end else if (r_cmd == CMD_VERSION) begin
            o_desc.kind = RESP_VERSION;
        end else begin
            o_desc.kind = RESP_UNSUPPORTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_addr     <= '0;
            r_length   <= '0;
            r_cmd      <= '0;
            r_crc      <= '0;
            r_prev     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_too_long <= n_too_long;
            r_addr     <= n_addr;
            r_length   <= n_length;
            r_cmd      <= n_cmd;
            r_crc      <= n_crc;
            r_prev     <= n_prev;
        end
    end

endmodule

// ===== rtl/fcr_desc_fifo.sv =====
// Short queue of response requests between the deframer and the response builder.
module fcr_desc_fifo
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_resp_desc  i_desc,
    input  logic        i_pop,
    output t_resp_desc  o_desc,
    output logic        o_empty,
    output logic        o_full
);

    t_resp_desc              r_mem [DESC_DEPTH];
    logic [DESC_PTR_W-1:0]   r_wr_ptr;
    logic [DESC_PTR_W-1:0]   r_rd_ptr;
    logic [DESC_PTR_W:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (DESC_PTR_W+1)'(DESC_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/fcr_back.sv =====
// Response builder: serializes one flagged, stuffed response per request, one byte per cycle while pops keep up.
module fcr_back
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_resp_desc  i_desc,
    input  logic        i_desc_empty,
    output logic        o_desc_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_response
);

    logic        r_busy;
    t_resp_desc  r_desc;
    logic [3:0]  r_idx;
    logic        r_esc;
    logic [7:0]  r_crc;
    logic        r_ovalid;
    logic [7:0]  r_tx;
    logic        r_last;

    logic        advance;
    logic        is_version;
    logic [3:0]  close_idx;
    logic [7:0]  len;
    logic [7:0]  status;
    logic [7:0]  msg_byte;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        msg_needs_esc;

    assign is_version = (r_desc.kind == RESP_VERSION);
    assign len        = is_version ? LEN_VERSION : LEN_SHORT;
    assign close_idx  = len[3:0] + 4'd1;

    always_comb begin
        case (r_desc.kind)
            RESP_VERSION:     status = i_cfg.status_success;
            RESP_UNSUPPORTED: status = i_cfg.status_unsupported;
            default:          status = i_cfg.status_crc_error;
        endcase
    end

    // Message byte at position r_idx - 1; the last one is the CRC.
    always_comb begin
        case (r_idx)
            4'd1:    msg_byte = i_cfg.own_addr;
            4'd2:    msg_byte = 8'h00;
            4'd3:    msg_byte = len;
            4'd4:    msg_byte = r_desc.cmd;
            4'd5:    msg_byte = status;
            4'd6:    msg_byte = is_version ? i_cfg.ver_hi : (r_crc ^ CRC_XOROUT);
            4'd7:    msg_byte = i_cfg.ver_lo;
            default: msg_byte = r_crc ^ CRC_XOROUT;
        endcase
    end

    assign msg_needs_esc = (msg_byte == FLAG_BYTE) || (msg_byte == ESC_BYTE);
    assign advance       = r_busy && (!r_ovalid || i_pop);
    assign o_desc_pop    = !r_busy && !i_desc_empty;

    always_comb begin
        out_last = 1'b0;
        if (r_idx == 4'd0) begin
            out_byte = FLAG_BYTE;
        end else if (r_idx == close_idx) begin
            out_byte = FLAG_BYTE;
            out_last = 1'b1;
        end else if (r_esc) begin
            out_byte = msg_byte ^ ESC_XOR;
        end else if (msg_needs_esc) begin
            out_byte = ESC_BYTE;
        end else begin
            out_byte = msg_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_esc    <= 1'b0;
            r_crc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_desc_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_esc  <= 1'b0;
                r_crc  <= '0;
            end else if (advance) begin
                if (r_idx == 4'd0) begin
                    r_idx <= 4'd1;
                end else if (r_idx == close_idx) begin
                    r_busy <= 1'b0;
                end else if (r_esc) begin
                    r_esc <= 1'b0;
                    r_idx <= r_idx + 4'd1;
                end else begin
                    // Fold each message byte into the CRC once, on its first wire byte;
                    // hold the CRC over the CRC byte so an escaped CRC keeps its value.
                    if (r_idx != len[3:0]) r_crc <= crc8_step(r_crc, msg_byte);
                    if (msg_needs_esc) begin
                        r_esc <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                end
            end

            if (advance) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_desc <= i_desc;
        end
        if (advance) begin
            r_tx   <= out_byte;
            r_last <= out_last;
        end
    end

    assign o_empty            = !r_ovalid;
    assign o_tx_byte          = r_tx;
    assign o_last_of_response = r_last;

endmodule
